FILE: rtl/aba_pkg.sv
package aba_pkg;

  // Field widths fixed by the interface
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DEPTH_FIELD_W = 7;
  // Header plus alignment padding stays below 128, so one extra bit holds the sum
  localparam int unsigned SUM_W         = DATA_W + 1;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MARK_DEPTH   = 64;
  localparam int unsigned DEF_ALIGN_BYTES  = 8;
  localparam int unsigned DEF_HEADER_BYTES = 8;

  // Arena capacity after reset
  localparam logic [DATA_W-1:0] ARENA_RESET = 32'd65536;

  // Request operation codes
  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_PUSH  = 2'd1,
    FN_POP   = 2'd2,
    FN_CLEAR = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOSPACE  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ALIGN = 2'd1,
    ST_POP   = 2'd2
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [DATA_W-1:0] req_size;
  } in_req_t;

  typedef struct packed {
    status_e                  status;
    logic [DATA_W-1:0]        data_offset;
    logic [DATA_W-1:0]        used_bytes;
    logic [DEPTH_FIELD_W-1:0] mark_depth;
    logic [DATA_W-1:0]        overflow_count;
  } out_rsp_t;

endpackage

FILE: rtl/aba_mark_mem.sv
module aba_mark_mem #(
  parameter int unsigned DEPTH = aba_pkg::DEF_MARK_DEPTH,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [aba_pkg::DATA_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [aba_pkg::DATA_W-1:0] rdata_o
);

  logic [aba_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [aba_pkg::DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/aba_align.sv
module aba_align #(
  parameter int unsigned ALIGN_BYTES = aba_pkg::DEF_ALIGN_BYTES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [aba_pkg::SUM_W-1:0]  sum_i,
  output logic                       done_o,
  output logic [aba_pkg::SUM_W-1:0]  total_o
);

  // sum_i already carries header plus (align - 1); total = sum - (sum mod align)
  localparam int unsigned NDIG   = (aba_pkg::SUM_W + 7) / 8;
  localparam int unsigned PAD_W  = NDIG * 8;
  localparam int unsigned CNT_W  = $clog2(NDIG + 1);
  localparam int unsigned ACC_W  = $clog2(ALIGN_BYTES * 256 + 1);
  localparam bit          POW2   = ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0);

  logic                      busy_q;
  logic                      done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [aba_pkg::SUM_W-1:0] s_q;
  logic [PAD_W-1:0]          sh_q;
  logic [ACC_W-1:0]          r_q;
  logic [ACC_W-1:0]          r_d;
  logic [aba_pkg::SUM_W-1:0] total_q;

  // One byte of remainder per step: r = (256 r + byte) mod align
  always_comb begin
    r_d = (r_q << 8) | ACC_W'(sh_q[PAD_W-1 -: 8]);
    for (int k = 7; k >= 0; k--) begin
      if (r_d >= (ACC_W'(ALIGN_BYTES) << k)) begin
        r_d = r_d - (ACC_W'(ALIGN_BYTES) << k);
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (POW2 || (cnt_q == CNT_W'(NDIG))) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q  <= sum_i;
      sh_q <= PAD_W'(sum_i);
      r_q  <= '0;
    end else if (busy_q) begin
      if (POW2) begin
        total_q <= s_q & ~aba_pkg::SUM_W'(ALIGN_BYTES - 1);
      end else if (cnt_q == CNT_W'(NDIG)) begin
        total_q <= s_q - aba_pkg::SUM_W'(r_q);
      end else begin
        r_q  <= r_d;
        sh_q <= sh_q << 8;
      end
    end
  end

  assign done_o  = done_q;
  assign total_o = total_q;

endmodule

FILE: rtl/arena_bump_allocator_with_marks_core.sv
// Bump allocator over a byte arena with a stack of saved fill marks held in a
// synchronous memory. One request is worked on at a time; its result lands in
// an output register, and the next request is taken no earlier than the cycle
// in which that result leaves, so a stalled result holds off new requests. Push,
// clear, and pop that only undoes a counted overflow or finds the stack empty
// load the result from idle. Pop that restores a mark waits for the registered
// mark read. Alloc masks the sum when ALIGN_BYTES is a power of two; otherwise
// the rounding remainder is found one byte of the 33-bit size sum per cycle.
// arena_size may be written only while no request is in flight.
module arena_bump_allocator_with_marks_core #(
  parameter int unsigned MARK_DEPTH   = aba_pkg::DEF_MARK_DEPTH,
  parameter int unsigned ALIGN_BYTES  = aba_pkg::DEF_ALIGN_BYTES,
  parameter int unsigned HEADER_BYTES = aba_pkg::DEF_HEADER_BYTES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  aba_pkg::in_req_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output aba_pkg::out_rsp_t          out_rsp_o,
  input  logic                       cfg_we_i,
  input  logic [aba_pkg::DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned TOP_W = $clog2(MARK_DEPTH + 1);
  localparam int unsigned AW    = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int unsigned CMP_W = aba_pkg::SUM_W + 1;

  aba_pkg::state_e            state_q, state_d;
  logic [aba_pkg::DATA_W-1:0] arena_q;
  logic [aba_pkg::DATA_W-1:0] fill_q, fill_d;
  logic [TOP_W-1:0]           top_q, top_d;
  logic [aba_pkg::DATA_W-1:0] excess_q, excess_d;
  logic                       out_valid_q, out_valid_d;
  aba_pkg::out_rsp_t          out_rsp_q, out_rsp_d;

  logic                       in_acc;
  logic                       load;
  aba_pkg::status_e           rsp_status;
  logic [aba_pkg::DATA_W-1:0] rsp_offset;
  logic [TOP_W-1:0]           top_m1;
  logic [CMP_W-1:0]           need;

  logic                       mem_we;
  logic                       mem_re;
  logic [aba_pkg::DATA_W-1:0] mem_rdata;

  logic                       al_start;
  logic                       al_done;
  logic [aba_pkg::SUM_W-1:0]  al_sum;
  logic [aba_pkg::SUM_W-1:0]  al_total;

  // Handshake
  assign in_stall_o  = (state_q != aba_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign top_m1 = top_q - 1'b1;
  assign al_sum = aba_pkg::SUM_W'(in_req_i.req_size)
                + aba_pkg::SUM_W'(HEADER_BYTES + ALIGN_BYTES - 1);
  assign need   = CMP_W'(fill_q) + CMP_W'(al_total);

  aba_align #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(al_start),
    .sum_i  (al_sum),
    .done_o (al_done),
    .total_o(al_total)
  );

  aba_mark_mem #(
    .DEPTH(MARK_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(top_q[AW-1:0]),
    .wdata_i(fill_q),
    .re_i   (mem_re),
    .raddr_i(top_m1[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  // Sequencer: next state, state updates and result
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    top_d      = top_q;
    excess_d   = excess_q;
    load       = 1'b0;
    rsp_status = aba_pkg::STAT_OK;
    rsp_offset = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    al_start   = 1'b0;

    unique case (state_q)
      aba_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req_i.func)
            aba_pkg::FN_ALLOC: begin
              al_start = 1'b1;
              state_d  = aba_pkg::ST_ALIGN;
            end
            aba_pkg::FN_PUSH: begin
              load = 1'b1;
              if (top_q != TOP_W'(MARK_DEPTH)) begin
                mem_we = 1'b1;
                top_d  = top_q + 1'b1;
              end else begin
                rsp_status = aba_pkg::STAT_OVERFLOW;
                if (excess_q != '1) begin
                  excess_d = excess_q + 1'b1;
                end
              end
            end
            aba_pkg::FN_POP: begin
              if (excess_q != '0) begin
                load     = 1'b1;
                excess_d = excess_q - 1'b1;
              end else if (top_q != '0) begin
                mem_re  = 1'b1;
                state_d = aba_pkg::ST_POP;
              end else begin
                load       = 1'b1;
                rsp_status = aba_pkg::STAT_EMPTY;
              end
            end
            aba_pkg::FN_CLEAR: begin
              load     = 1'b1;
              fill_d   = '0;
              top_d    = '0;
              excess_d = '0;
            end
            default: begin
              state_d = aba_pkg::ST_IDLE;
            end
          endcase
        end
      end
      aba_pkg::ST_ALIGN: begin
        if (al_done) begin
          load    = 1'b1;
          state_d = aba_pkg::ST_IDLE;
          if (need <= CMP_W'(arena_q)) begin
            rsp_offset = fill_q + aba_pkg::DATA_W'(HEADER_BYTES);
            fill_d     = need[aba_pkg::DATA_W-1:0];
          end else begin
            rsp_status = aba_pkg::STAT_NOSPACE;
          end
        end
      end
      aba_pkg::ST_POP: begin
        load    = 1'b1;
        fill_d  = mem_rdata;
        top_d   = top_m1;
        state_d = aba_pkg::ST_IDLE;
      end
      default: begin
        state_d = aba_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    if (load) begin
      out_valid_d              = 1'b1;
      out_rsp_d.status         = rsp_status;
      out_rsp_d.data_offset    = rsp_offset;
      out_rsp_d.used_bytes     = fill_d;
      out_rsp_d.mark_depth     = aba_pkg::DEPTH_FIELD_W'(top_d);
      out_rsp_d.overflow_count = excess_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aba_pkg::ST_IDLE;
      arena_q     <= aba_pkg::ARENA_RESET;
      fill_q      <= '0;
      top_q       <= '0;
      excess_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      top_q       <= top_d;
      excess_q    <= excess_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        arena_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  // Depth never exceeds the stack size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TOP_W'(MARK_DEPTH))
    else $error("mark depth beyond stack size");

  // Overflow pushes are only counted on a full stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    excess_q != '0 |-> top_q == TOP_W'(MARK_DEPTH))
    else $error("overflow count with stack not full");

  // A mark restore removes exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == aba_pkg::ST_POP |=> top_q == $past(top_q) - 1'b1)
    else $error("pop did not drop one mark");

  // The align unit reports only while an alloc waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    al_done |-> state_q == aba_pkg::ST_ALIGN)
    else $error("align result outside alloc");

endmodule
